// ===== rtl/core/khgp_pkg.sv =====
package khgp_pkg;

    localparam logic [31:0] GOLDEN        = 32'h9e3779b9;
    localparam int          GROUP_BITS    = 16;
    localparam int          GROUP_COUNT_W = GROUP_BITS + 1;
    localparam int          MIX_STEPS     = 9;
    localparam int          STEP_W        = $clog2(MIX_STEPS);
    localparam int          DIV_CNT_W     = 5;

    localparam logic [GROUP_COUNT_W-1:0] DIV_LIMIT = GROUP_COUNT_W'(1) << GROUP_BITS;
    localparam logic [STEP_W-1:0]        STEP_LAST = STEP_W'(MIX_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MIX  = 5'b00010,
        S_LEN  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // One step of the lookup2 mix: x -= y; x -= z; x ^= shifted z.
    function automatic logic [31:0] mix_step(input logic [STEP_W-1:0] step,
                                             input logic [31:0] x,
                                             input logic [31:0] y,
                                             input logic [31:0] z);
        logic [31:0] diff;
        logic [31:0] sh;
        diff = x - y - z;
        case (step)
            4'd0:    sh = z >> 13;
            4'd1:    sh = z << 8;
            4'd2:    sh = z >> 13;
            4'd3:    sh = z >> 12;
            4'd4:    sh = z << 16;
            4'd5:    sh = z >> 5;
            4'd6:    sh = z >> 3;
            4'd7:    sh = z << 10;
            4'd8:    sh = z >> 15;
            default: sh = '0;
        endcase
        return diff ^ sh;
    endfunction

endpackage

// ===== rtl/core/key_hash_group_placement.sv =====
// A word that does not close a 12-byte block is only accumulated; one that closes
// a block starts the mix, which runs one step per cycle on a shared subtract/xor/shift
// unit. A last word leads into a length step, the final mix, a bit-serial remainder
// and a load of the output register.
// Input ready is low while the sequencer runs; a result waits in an output register.
// Reset (rst_n, asynchronous, active low) restarts the key and sets group_count to 1.
module key_hash_group_placement (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // key_word [31:0], byte_count [34:32], zero [39:35]
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // hash_value [31:0], target_group [47:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data        // group_count
);

    localparam int GB  = khgp_pkg::GROUP_BITS;
    localparam int GCW = khgp_pkg::GROUP_COUNT_W;
    localparam int SW  = khgp_pkg::STEP_W;
    localparam int DCW = khgp_pkg::DIV_CNT_W;

    khgp_pkg::state_t state_reg, state_next;

    logic [31:0]     mix_first_reg, mix_first_next;
    logic [31:0]     mix_second_reg, mix_second_next;
    logic [31:0]     mix_third_reg, mix_third_next;
    logic [31:0]     key_length_reg, key_length_next;
    logic [1:0]      word_slot_reg, word_slot_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            last_reg, last_next;
    logic            final_reg, final_next;
    logic [DCW-1:0]  div_cnt_reg, div_cnt_next;
    logic [GB-1:0]   rem_reg, rem_next;
    logic [GCW-1:0]  group_count_reg;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     hash_out_reg, hash_out_next;
    logic [GB-1:0]   group_out_reg, group_out_next;

    logic            s_acc;
    logic            load_out;
    logic [2:0]      nbytes;
    logic [31:0]     word;
    logic [GCW-1:0]  divisor;
    logic [GCW-1:0]  rem_shift;
    logic [31:0]     mix_new;

    assign s_axis_tready = (state_reg == khgp_pkg::S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {group_out_reg, hash_out_reg};

    assign nbytes = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];

    always_comb
    begin
        case (nbytes)
            3'd0:    word = 32'h0;
            3'd1:    word = {24'h0, s_axis_tdata[7:0]};
            3'd2:    word = {16'h0, s_axis_tdata[15:0]};
            3'd3:    word = {8'h0, s_axis_tdata[23:0]};
            default: word = s_axis_tdata[31:0];
        endcase
    end

    // A zero count means a single group; counts beyond the field range saturate.
    always_comb
    begin
        if (group_count_reg == '0)
        begin
            divisor = GCW'(1);
        end
        else if (group_count_reg > khgp_pkg::DIV_LIMIT)
        begin
            divisor = khgp_pkg::DIV_LIMIT;
        end
        else
        begin
            divisor = group_count_reg;
        end
    end

    assign rem_shift = {rem_reg, mix_third_reg[div_cnt_reg]};
    assign mix_new   = khgp_pkg::mix_step(step_reg, mix_first_reg, mix_second_reg,
                                          mix_third_reg);
    assign load_out  = (state_reg == khgp_pkg::S_DONE) &&
                       (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        mix_first_next  = mix_first_reg;
        mix_second_next = mix_second_reg;
        mix_third_next  = mix_third_reg;
        key_length_next = key_length_reg;
        word_slot_next  = word_slot_reg;
        step_next       = step_reg;
        last_next       = last_reg;
        final_next      = final_reg;
        div_cnt_next    = div_cnt_reg;
        rem_next        = rem_reg;
        hash_out_next   = hash_out_reg;
        group_out_next  = group_out_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        case (state_reg)
            khgp_pkg::S_IDLE:
            begin
                if (s_acc)
                begin
                    last_next  = s_axis_tlast;
                    final_next = 1'b0;
                    step_next  = '0;
                    if (nbytes != 3'd0 || s_axis_tlast)
                    begin
                        key_length_next = key_length_reg + {29'h0, nbytes};
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = khgp_pkg::S_LEN;
                    end
                    if (nbytes != 3'd0)
                    begin
                        case (word_slot_reg)
                            2'd0:
                            begin
                                mix_first_next = mix_first_reg + word;
                                word_slot_next = 2'd1;
                            end
                            2'd1:
                            begin
                                mix_second_next = mix_second_reg + word;
                                word_slot_next  = 2'd2;
                            end
                            default:
                            begin
                                // A short last word in the third slot lands one byte up.
                                if (nbytes == 3'd4 || !s_axis_tlast)
                                begin
                                    mix_third_next = mix_third_reg + word;
                                    word_slot_next = 2'd0;
                                    state_next     = khgp_pkg::S_MIX;
                                end
                                else
                                begin
                                    mix_third_next = mix_third_reg + (word << 8);
                                end
                            end
                        endcase
                    end
                end
            end

            khgp_pkg::S_MIX:
            begin
                // Rotating the three words lets every step use the same unit.
                mix_first_next  = mix_second_reg;
                mix_second_next = mix_third_reg;
                mix_third_next  = mix_new;
                step_next       = step_reg + SW'(1);
                if (step_reg == khgp_pkg::STEP_LAST)
                begin
                    step_next = '0;
                    if (final_reg)
                    begin
                        state_next   = khgp_pkg::S_DIV;
                        rem_next     = '0;
                        div_cnt_next = '1;
                    end
                    else if (last_reg)
                    begin
                        state_next = khgp_pkg::S_LEN;
                    end
                    else
                    begin
                        state_next = khgp_pkg::S_IDLE;
                    end
                end
            end

            khgp_pkg::S_LEN:
            begin
                mix_third_next = mix_third_reg + key_length_reg;
                final_next     = 1'b1;
                step_next      = '0;
                state_next     = khgp_pkg::S_MIX;
            end

            khgp_pkg::S_DIV:
            begin
                if (rem_shift >= divisor)
                begin
                    rem_next = GB'(rem_shift - divisor);
                end
                else
                begin
                    rem_next = GB'(rem_shift);
                end
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = khgp_pkg::S_DONE;
                end
            end

            khgp_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    hash_out_next   = mix_third_reg;
                    group_out_next  = rem_reg;
                    out_valid_next  = 1'b1;
                    mix_first_next  = khgp_pkg::GOLDEN;
                    mix_second_next = khgp_pkg::GOLDEN;
                    mix_third_next  = '0;
                    key_length_next = '0;
                    word_slot_next  = '0;
                    last_next       = 1'b0;
                    final_next      = 1'b0;
                    state_next      = khgp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = khgp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= khgp_pkg::S_IDLE;
            mix_first_reg   <= khgp_pkg::GOLDEN;
            mix_second_reg  <= khgp_pkg::GOLDEN;
            mix_third_reg   <= '0;
            key_length_reg  <= '0;
            word_slot_reg   <= '0;
            step_reg        <= '0;
            last_reg        <= 1'b0;
            final_reg       <= 1'b0;
            div_cnt_reg     <= '0;
            group_count_reg <= GCW'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mix_first_reg  <= mix_first_next;
            mix_second_reg <= mix_second_next;
            mix_third_reg  <= mix_third_next;
            key_length_reg <= key_length_next;
            word_slot_reg  <= word_slot_next;
            step_reg       <= step_next;
            last_reg       <= last_next;
            final_reg      <= final_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                group_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        hash_out_reg  <= hash_out_next;
        group_out_reg <= group_out_next;
    end

    // A last word always leads into the length and final mix phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tlast) |=> (state_reg == khgp_pkg::S_LEN ||
                                     state_reg == khgp_pkg::S_MIX))
        else $error("last word did not start the final phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= khgp_pkg::STEP_LAST)
        else $error("mix step counter out of range");

    // The partial remainder stays below the divisor through the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == khgp_pkg::S_DIV) |=> ({1'b0, rem_reg} < divisor))
        else $error("remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && mix_first_reg == khgp_pkg::GOLDEN &&
                      key_length_reg == '0 && word_slot_reg == '0))
        else $error("key state not restarted after result");

endmodule
